@@ design/bbc_pkg.sv @@
// Shared types, character codes and the character decoder for the bracket
// balance checker. No dependencies; every other design file depends on it.
package bbc_pkg;

  // Bracket kind held in one stack cell
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  // ASCII codes of the six brackets
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    V_OK      = 2'd0,
    V_MISSING = 2'd1,
    V_ERRORS  = 2'd2,
    V_BUSY    = 2'd3
  } verdict_t;

  // Shift command broadcast along the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    status_t     char_status;
    logic [15:0] position;
    logic        done_res;
    verdict_t    verdict;
  } result_t;

  // Sort one byte into opener, closer or other
  function automatic char_class_t classify(logic [7:0] ch);
    char_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    case (ch)
      CH_LPAREN:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_LSQUARE: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_LCURLY:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_RPAREN:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_RSQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_RCURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return c;
  endfunction

endpackage

@@ design/bbc_if.sv @@
// Valid/ready channel interfaces for the bracket balance checker.
// Depends on bbc_pkg for the result field types.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface bbc_out_if;
  logic              valid;
  logic              ready;
  bbc_pkg::status_t  char_status;
  logic [15:0]       position;
  logic              done_res;
  bbc_pkg::verdict_t verdict;

  modport source (output valid, output char_status, output position, output done_res,
                  output verdict, input ready);
  modport sink (input valid, input char_status, input position, input done_res,
                input verdict, output ready);
endinterface

@@ design/bracket_balance_checker_core.sv @@
// Top level of the bracket balance checker: decoder, stack depth counter,
// chain of bbc_cell stack cells and the bbc_out_skid output stage.
// Depends on bbc_pkg, bbc_if, bbc_cell and bbc_out_skid.
//
//   channel | direction | words carried
//   in_if   | sink      | char_code, is_last
//   out_if  | source    | char_status, position, done_res, verdict
//
// One word is taken per cycle while in_if.ready is high; its result goes to
// the output register, or to the skid stage while that register stalls. The
// cell chain does one push or pop shift per cycle, stack top always in cell 0.
// Reset (rst_n low, synchronous) clears the depth count, error flag, index
// and output valid bits; the cells are not reset.
// A stalled output holds its word while one more word drops into the skid
// stage; in_if.ready falls only while the skid stage is occupied.
module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bbc_in_if.sink    in_if,
  bbc_out_if.source out_if
);
  import bbc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic             accept;
  char_class_t      cls;
  logic             full;
  logic             empty;
  shift_t           shift;
  status_t          status;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             err_r;
  logic             err_nxt;
  logic [15:0]      idx_r;
  logic [15:0]      idx_nxt;
  result_t          res;
  logic             wr_ready;
  kind_t            kind_w [STACK_DEPTH];

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = wr_ready;
  assign cls         = classify(in_if.char_code);
  assign full        = (count_r == CNT_W'(STACK_DEPTH));
  assign empty       = (count_r == '0);

  // Push on an opener with room, pop on a closer with something to pop
  assign shift.push = accept && cls.is_open && !full;
  assign shift.pop  = accept && cls.is_close && !empty;

  // Classify this word's error
  always_comb begin
    status = ST_NONE;
    if (cls.is_open && full) begin
      status = ST_OVERFLOW;
    end else if (cls.is_close && empty) begin
      status = ST_EMPTY;
    end else if (cls.is_close && (kind_w[0] != cls.kind)) begin
      status = ST_MISMATCH;
    end
  end

  // Next depth, error flag and saturating index
  always_comb begin
    count_nxt = count_r;
    if (shift.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (shift.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    err_nxt = err_r || (status != ST_NONE);
    idx_nxt = (idx_r == POS_MAX) ? idx_r : idx_r + 16'd1;
  end

  // Build the result word
  always_comb begin
    res.char_status = status;
    res.position    = idx_r;
    res.done_res    = in_if.is_last;
    res.verdict     = V_BUSY;
    if (in_if.is_last) begin
      if (count_nxt != '0) begin
        res.verdict = V_MISSING;
      end else if (err_nxt) begin
        res.verdict = V_ERRORS;
      end else begin
        res.verdict = V_OK;
      end
    end
  end

  // Advance string state; drop it after the last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= 1'b0;
      idx_r   <= '0;
    end else if (accept) begin
      if (in_if.is_last) begin
        count_r <= '0;
        err_r   <= 1'b0;
        idx_r   <= '0;
      end else begin
        count_r <= count_nxt;
        err_r   <= err_nxt;
        idx_r   <= idx_nxt;
      end
    end
  end

  // Stack cells; cell 0 holds the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t up_w;
    kind_t dn_w;
    if (i == 0) begin : g_top
      assign up_w = cls.kind;
    end else begin : g_mid_up
      assign up_w = kind_w[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign dn_w = KIND_PAREN;
    end else begin : g_mid_dn
      assign dn_w = kind_w[i+1];
    end
    bbc_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .from_up (up_w),
      .from_dn (dn_w),
      .kind_r  (kind_w[i])
    );
  end

  bbc_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (accept),
    .wr_data  (res),
    .wr_ready (wr_ready),
    .out_if   (out_if)
  );

endmodule

@@ design/bbc_cell.sv @@
// One stack cell: holds a bracket kind, takes its upper neighbor's kind on a
// push and its lower neighbor's kind on a pop. Depends on bbc_pkg.
module bbc_cell (
  input  logic            clk,
  input  bbc_pkg::shift_t shift,
  input  bbc_pkg::kind_t  from_up,
  input  bbc_pkg::kind_t  from_dn,
  output bbc_pkg::kind_t  kind_r
);

  // Shift down on push, up on pop, hold otherwise
  always_ff @(posedge clk) begin
    if (shift.push) begin
      kind_r <= from_up;
    end else if (shift.pop) begin
      kind_r <= from_dn;
    end
  end

endmodule

@@ design/bbc_out_skid.sv @@
// Output register with a skid stage for the result channel; the upstream
// ready depends only on the skid stage. Depends on bbc_pkg and bbc_if.
module bbc_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  bbc_pkg::result_t wr_data,
  output logic             wr_ready,
  bbc_out_if.source        out_if
);
  import bbc_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    out_fire;

  assign wr_ready = !skid_valid_r;
  assign out_fire = main_valid_r && out_if.ready;

  // Refill the output register from the skid stage first, else from upstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_fire) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= wr_valid;
      end
    end else if (wr_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves with the valid flags above
  always_ff @(posedge clk) begin
    if (!main_valid_r || out_fire) begin
      main_r <= skid_valid_r ? skid_r : wr_data;
    end else if (wr_valid) begin
      skid_r <= wr_data;
    end
  end

  assign out_if.valid       = main_valid_r;
  assign out_if.char_status = main_r.char_status;
  assign out_if.position    = main_r.position;
  assign out_if.done_res    = main_r.done_res;
  assign out_if.verdict     = main_r.verdict;

endmodule

@@ design/bbc_checker.sv @@
// Port-level checks for bracket_balance_checker_core, attached by bind.
// Depends on bbc_pkg.
module bbc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bbc_pkg::status_t  out_char_status,
  input logic [15:0]       out_position,
  input logic              out_done_res,
  input bbc_pkg::verdict_t out_verdict
);
  import bbc_pkg::*;

  logic new_str_r;

  // Track whether the next word delivered starts a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_str_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      new_str_r <= out_done_res;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_status)
      && $stable(out_position) && $stable(out_done_res) && $stable(out_verdict))
    else $error("stalled result word changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_verdict == V_BUSY)
    else $error("verdict given before end of string");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_verdict != V_BUSY)
    else $error("end of string without verdict");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && new_str_r |-> out_position == 16'd0)
    else $error("string did not restart at position zero");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_char_status (out_if.char_status),
  .out_position    (out_if.position),
  .out_done_res    (out_if.done_res),
  .out_verdict     (out_if.verdict)
);
